[rtl/jhs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jhs_pkg
// Shared widths, register map, window cell and result queue types for the
// five-point stencil sweep.
// ----------------------------------------------------------------------------
package jhs_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int TEMP_W     = 16;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 11;
    localparam int SUM_W      = TEMP_W + 2;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1000);
    localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(3);

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic [TEMP_W-1:0] older;
        logic [TEMP_W-1:0] newer;
    } t_cell;

    typedef struct packed {
        logic [TEMP_W-1:0] val0;
        logic [TEMP_W-1:0] val1;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              two;
        logic              done;
    } t_entry;

    // last usable index of a dimension, saturated to MIN..hi
    function automatic logic [COL_W-1:0] last_index(input logic [DIM_W-1:0] v,
                                                    input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] c;
        begin
            if (v < DIM_MIN) begin
                c = DIM_MIN;
            end else if (v > hi) begin
                c = hi;
            end else begin
                c = v;
            end
            last_index = COL_W'(c - DIM_W'(1));
        end
    endfunction

endpackage
`default_nettype wire

[rtl/jacobi_heat_stencil_sweep.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_heat_stencil_sweep
// One Jacobi five-point sweep over a plate streamed in raster order.
// ----------------------------------------------------------------------------
// Input channel: one Q8.8 cell temperature per beat, raster order, on
// i_cell_valid / o_cell_ready. Output channel: result beats carrying the new
// temperature and its row and column on o_res_valid / i_res_ready.
// Results lag the input by one row: the beat for row i emits cell (i-1, j),
// and in the last row also its own cell, unchanged, as a second beat.
// Each result is registered in the result queue before it appears.
// Throughput: one cell per cycle while the result queue has room; in the last
// row each cell yields two result beats, and the output sends one per cycle.
// The two stored rows sit in one RAM with registered read, read one column
// ahead of the window cells; the window fills itself during row 0.
// A full two-entry result queue drops o_cell_ready, so a stalled receiver
// holds the input side once two entries from row 1 on are waiting; row 0
// beats carry no results but are held as well while the queue is full.
// Reset: grid registers to 1000, raster position to the origin, queue
// empty; no clearing pass. A register write over APB restarts the sweep.
// ----------------------------------------------------------------------------
module jacobi_heat_stencil_sweep (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [jhs_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [jhs_pkg::DATA_W-1:0]       pwdata,
    output logic      [jhs_pkg::DATA_W-1:0]       prdata,
    output logic                                  pready,
    input  wire logic                             i_cell_valid,
    output logic                                  o_cell_ready,
    input  wire logic [jhs_pkg::TEMP_W-1:0]       i_cell_temp,
    output logic                                  o_res_valid,
    input  wire logic                             i_res_ready,
    output logic      [jhs_pkg::TEMP_W-1:0]       o_new_temp,
    output logic      [jhs_pkg::ROW_W-1:0]        o_out_row,
    output logic      [jhs_pkg::COL_W-1:0]        o_out_col,
    output logic                                  o_run_last,
    output logic                                  o_sweep_done
);

    logic [jhs_pkg::DIM_W-1:0] r_grid_width, n_grid_width;
    logic [jhs_pkg::DIM_W-1:0] r_grid_height, n_grid_height;
    logic [jhs_pkg::ROW_W-1:0] r_row, n_row;
    logic [jhs_pkg::COL_W-1:0] r_col, n_col;
    logic [jhs_pkg::COL_W-1:0] r_rd_col, n_rd_col;
    logic [jhs_pkg::COL_W-1:0] w_last;
    logic [jhs_pkg::ROW_W-1:0] h_last;
    logic                      cfg_wr;
    logic                      accept;
    logic                      q_full;
    logic                      border;
    logic                      last_row;
    logic [jhs_pkg::SUM_W-1:0] sum;
    logic [$bits(jhs_pkg::t_cell)-1:0] ram_wdata;
    logic [$bits(jhs_pkg::t_cell)-1:0] ram_rdata;
    jhs_pkg::t_cell            ram_q;
    jhs_pkg::t_cell            cur;
    jhs_pkg::t_cell            lft;
    jhs_pkg::t_entry           entry;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        case (paddr[2])
            jhs_pkg::REG_GRID_WIDTH:  prdata = jhs_pkg::DATA_W'(r_grid_width);
            jhs_pkg::REG_GRID_HEIGHT: prdata = jhs_pkg::DATA_W'(r_grid_height);
            default:                  prdata = '0;
        endcase
    end

    assign w_last = jhs_pkg::last_index(r_grid_width,
                                        jhs_pkg::DIM_W'(jhs_pkg::MAX_WIDTH));
    assign h_last = jhs_pkg::ROW_W'(jhs_pkg::last_index(r_grid_height,
                                        jhs_pkg::DIM_W'(jhs_pkg::MAX_HEIGHT)));

    assign o_cell_ready = !q_full;
    assign accept       = i_cell_valid && o_cell_ready;

    always_comb begin
        n_grid_width  = r_grid_width;
        n_grid_height = r_grid_height;
        n_row         = r_row;
        n_col         = r_col;
        n_rd_col      = r_rd_col;
        if (cfg_wr) begin
            case (paddr[2])
                jhs_pkg::REG_GRID_WIDTH:  n_grid_width  = pwdata[jhs_pkg::DIM_W-1:0];
                jhs_pkg::REG_GRID_HEIGHT: n_grid_height = pwdata[jhs_pkg::DIM_W-1:0];
                default:                  n_grid_width  = r_grid_width;
            endcase
            n_row    = '0;
            n_col    = '0;
            n_rd_col = jhs_pkg::COL_W'(2);
        end else if (accept) begin
            if (r_col == w_last) begin
                n_col = '0;
                n_row = (r_row == h_last) ? '0 : r_row + jhs_pkg::ROW_W'(1);
            end else begin
                n_col = r_col + jhs_pkg::COL_W'(1);
            end
            n_rd_col = (r_rd_col == w_last) ? '0 : r_rd_col + jhs_pkg::COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= jhs_pkg::DIM_RESET;
            r_grid_height <= jhs_pkg::DIM_RESET;
            r_row         <= '0;
            r_col         <= '0;
            r_rd_col      <= jhs_pkg::COL_W'(2);
        end else begin
            r_grid_width  <= n_grid_width;
            r_grid_height <= n_grid_height;
            r_row         <= n_row;
            r_col         <= n_col;
            r_rd_col      <= n_rd_col;
        end
    end

    assign ram_wdata = {cur.newer, i_cell_temp};
    assign ram_q     = jhs_pkg::t_cell'(ram_rdata);

    jhs_ram #(
        .WIDTH ($bits(jhs_pkg::t_cell)),
        .DEPTH (jhs_pkg::MAX_WIDTH)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (r_rd_col),
        .o_rdata (ram_rdata)
    );

    jhs_cell u_cell_cur (
        .i_clk (i_clk),
        .i_en  (accept),
        .i_d   (ram_q),
        .o_q   (cur)
    );

    jhs_cell u_cell_left (
        .i_clk (i_clk),
        .i_en  (accept),
        .i_d   (cur),
        .o_q   (lft)
    );

    always_comb begin
        last_row = (r_row == h_last);
        border   = (r_row == jhs_pkg::ROW_W'(1)) || (r_col == '0) || (r_col == w_last);
        sum      = jhs_pkg::SUM_W'(cur.older) + jhs_pkg::SUM_W'(i_cell_temp)
                 + jhs_pkg::SUM_W'(lft.newer) + jhs_pkg::SUM_W'(ram_q.newer);
        entry.val0 = border ? cur.newer : sum[jhs_pkg::SUM_W-1:2];
        entry.val1 = i_cell_temp;
        entry.row  = r_row - jhs_pkg::ROW_W'(1);
        entry.col  = r_col;
        entry.two  = last_row;
        entry.done = (r_col == w_last);
    end

    jhs_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (accept && (r_row != '0)),
        .i_entry      (entry),
        .o_full       (q_full),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_new_temp   (o_new_temp),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_run_last   (o_run_last),
        .o_sweep_done (o_sweep_done)
    );

endmodule
`default_nettype wire

[rtl/jhs_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jhs_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module jhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/jhs_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jhs_cell
// One column of the stencil window: holds the two stored rows of a column
// and hands them to the next cell on every accepted beat.
// ----------------------------------------------------------------------------
module jhs_cell (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire jhs_pkg::t_cell i_d,
    output jhs_pkg::t_cell     o_q
);

    jhs_pkg::t_cell r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

[rtl/jhs_outq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jhs_outq
// Two-entry result queue; each entry carries one or two result beats and
// is split into beats at the head.
// ----------------------------------------------------------------------------
module jhs_outq (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  wire jhs_pkg::t_entry                 i_entry,
    output logic                                 o_full,
    output logic                                 o_res_valid,
    input  wire logic                            i_res_ready,
    output logic [jhs_pkg::TEMP_W-1:0]           o_new_temp,
    output logic [jhs_pkg::ROW_W-1:0]            o_out_row,
    output logic [jhs_pkg::COL_W-1:0]            o_out_col,
    output logic                                 o_run_last,
    output logic                                 o_sweep_done
);

    jhs_pkg::t_entry r_q [2];
    jhs_pkg::t_entry head;
    logic            r_wp, n_wp;
    logic            r_rp, n_rp;
    logic [1:0]      r_cnt, n_cnt;
    logic            r_sub, n_sub;
    logic            pop;
    logic            last_beat;
    logic            retire;

    always_comb begin
        head      = r_q[r_rp];
        pop       = o_res_valid && i_res_ready;
        last_beat = !head.two || r_sub;
        retire    = pop && last_beat;
        n_sub     = r_sub;
        if (pop) begin
            n_sub = !last_beat;
        end
        n_wp  = i_push ? !r_wp : r_wp;
        n_rp  = retire ? !r_rp : r_rp;
        n_cnt = r_cnt + 2'(i_push) - 2'(retire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
            r_sub <= 1'b0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
            r_sub <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_entry;
        end
    end

    assign o_full       = (r_cnt == 2'd2);
    assign o_res_valid  = (r_cnt != 2'd0);
    assign o_new_temp   = r_sub ? head.val1 : head.val0;
    assign o_out_row    = head.row + jhs_pkg::ROW_W'(r_sub);
    assign o_out_col    = head.col;
    assign o_run_last   = last_beat;
    assign o_sweep_done = r_sub && head.done;

endmodule
`default_nettype wire
